// ===== hw/rtl/bilinear_upscale_2x_core_macros.svh =====
// Assertion macros shared by the upscaler RTL.
`ifndef BILINEAR_UPSCALE_2X_CORE_MACROS_SVH
`define BILINEAR_UPSCALE_2X_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BU2X_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BU2X_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bu2x_pkg.sv =====
// Types, constants and sequencing functions of the 2x bilinear upscaler.
`timescale 1ns / 1ps

package bu2x_pkg;

    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int OUT_ROW_W    = 13;
    localparam int OUT_COL_W    = 12;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // One member per kind of output pixel an input can produce, in emit order.
    typedef enum logic [3:0] {
        K_CORNER_TL,  // (0,0) copy
        K_TOP_A,      // (0,2c-1)
        K_TOP_B,      // (0,2c)
        K_CORNER_TR,  // (0,2W-1) copy
        K_LEFT_A,     // (2r-1,0)
        K_LEFT_B,     // (2r,0)
        K_CORNER_BL,  // (2H-1,0) copy
        K_INT_A,      // (2r-1,2c-1)
        K_INT_B,      // (2r-1,2c)
        K_RIGHT_A,    // (2r-1,2W-1)
        K_INT_C,      // (2r,2c-1)
        K_INT_D,      // (2r,2c)
        K_RIGHT_B,    // (2r,2W-1)
        K_BOT_A,      // (2H-1,2c-1)
        K_BOT_B,      // (2H-1,2c)
        K_CORNER_BR   // (2H-1,2W-1) copy
    } t_kind;

    typedef struct packed {
        logic last_col;
        logic last_row;
    } t_flags;

    typedef struct packed {
        logic  done;
        t_kind kind;
    } t_step;

    function automatic t_kind bu2x_first_kind(input logic row_zero, input logic col_zero);
        t_kind k;
        if (row_zero) begin
            k = col_zero ? K_CORNER_TL : K_TOP_A;
        end else begin
            k = col_zero ? K_LEFT_A : K_INT_A;
        end
        return k;
    endfunction

    function automatic t_step bu2x_next_step(input t_kind k, input t_flags f);
        t_step s;
        s.done = 1'b0;
        s.kind = k;
        case (k)
            K_CORNER_TL: begin
                if (f.last_col) s.kind = K_CORNER_TR;
                else            s.done = 1'b1;
            end
            K_TOP_A:     s.kind = K_TOP_B;
            K_TOP_B: begin
                if (f.last_col) s.kind = K_CORNER_TR;
                else            s.done = 1'b1;
            end
            K_LEFT_A:    s.kind = K_LEFT_B;
            K_LEFT_B: begin
                if (f.last_row) s.kind = K_CORNER_BL;
                else            s.done = 1'b1;
            end
            K_INT_A:     s.kind = K_INT_B;
            K_INT_B:     s.kind = f.last_col ? K_RIGHT_A : K_INT_C;
            K_RIGHT_A:   s.kind = K_INT_C;
            K_INT_C:     s.kind = K_INT_D;
            K_INT_D: begin
                if (f.last_col)      s.kind = K_RIGHT_B;
                else if (f.last_row) s.kind = K_BOT_A;
                else                 s.done = 1'b1;
            end
            K_RIGHT_B: begin
                if (f.last_row) s.kind = K_BOT_A;
                else            s.done = 1'b1;
            end
            K_BOT_A:     s.kind = K_BOT_B;
            K_BOT_B: begin
                if (f.last_col) s.kind = K_CORNER_BR;
                else            s.done = 1'b1;
            end
            default:     s.done = 1'b1;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/bu2x_pix_if.sv =====
// Input pixel channel: valid/ready with one pixel per item.
`timescale 1ns / 1ps

interface bu2x_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== hw/rtl/bu2x_res_if.sv =====
// Result channel: valid/ready with one output pixel and its coordinates per item.
`timescale 1ns / 1ps

interface bu2x_res_if #(
    parameter int PIXEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [12:0]           out_row;
    logic [11:0]           out_col;
    logic [PIXEL_BITS-1:0] result_value;
    logic                  last_of_run;

    modport source (output valid, output out_row, output out_col, output result_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input result_value,
                    input last_of_run, output ready);
endinterface

// ===== hw/rtl/bu2x_emit.sv =====
// Result sequencer: walks an input's outputs, one weighted sum per unstalled cycle.
`timescale 1ns / 1ps

module bu2x_emit
    import bu2x_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int COL_BITS   = 11,
    parameter int ROW_BITS   = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_vld,
    output logic                  o_job_rdy,
    input  logic [PIXEL_BITS-1:0] i_p,
    input  logic [PIXEL_BITS-1:0] i_u,
    input  logic [PIXEL_BITS-1:0] i_ul,
    input  logic [PIXEL_BITS-1:0] i_l,
    input  logic [ROW_BITS-1:0]   i_row,
    input  logic [COL_BITS-1:0]   i_col,
    input  t_flags                i_flags,
    input  logic [COL_BITS-1:0]   i_w_last,
    input  logic [ROW_BITS-1:0]   i_h_last,
    bu2x_res_if.source            o_res
);

    localparam int SW = PIXEL_BITS + 5;

    logic                  r_busy, n_busy;
    t_kind                 r_kind, n_kind;
    logic [PIXEL_BITS-1:0] r_p, r_u, r_ul, r_l;
    logic [ROW_BITS-1:0]   r_row;
    logic [COL_BITS-1:0]   r_col;
    t_flags                r_flags;

    logic                  r_o_vld;
    logic [OUT_ROW_W-1:0]  r_o_row;
    logic [OUT_COL_W-1:0]  r_o_col;
    logic [PIXEL_BITS-1:0] r_o_val;
    logic                  r_o_last;

    logic                  out_free, fire, load;
    t_step                 step;

    logic [ROW_BITS:0]     row_x2, row_m1;
    logic [COL_BITS:0]     col_x2, col_m1;
    logic [OUT_ROW_W-1:0]  sel_row;
    logic [OUT_COL_W-1:0]  sel_col;
    logic [PIXEL_BITS-1:0] op_n, op_s1, op_s2, op_f;
    logic [SW-1:0]         e_n, e_s1, e_s2, e_f, sum;

    assign out_free  = !r_o_vld || o_res.ready;
    assign fire      = r_busy && out_free;
    assign step      = bu2x_next_step(r_kind, r_flags);
    assign o_job_rdy = !r_busy || (fire && step.done);
    assign load      = i_job_vld && o_job_rdy;

    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        if (load) begin
            n_busy = 1'b1;
            n_kind = bu2x_first_kind(i_row == '0, i_col == '0);
        end else if (fire) begin
            n_busy = !step.done;
            n_kind = step.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= K_CORNER_TL;
        end else begin
            r_busy <= n_busy;
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p     <= i_p;
            r_u     <= i_u;
            r_ul    <= i_ul;
            r_l     <= i_l;
            r_row   <= i_row;
            r_col   <= i_col;
            r_flags <= i_flags;
        end
    end

    assign row_x2 = {r_row, 1'b0};
    assign row_m1 = row_x2 - 1'b1;
    assign col_x2 = {r_col, 1'b0};
    assign col_m1 = col_x2 - 1'b1;

    // Two-tap edges reuse the four-tap sum: mix2(a,b) == mix4(a,a,b,b),
    // and a copy is mix4(p,p,p,p).
    always_comb begin
        sel_row = '0;
        sel_col = '0;
        op_n    = r_p;
        op_s1   = r_p;
        op_s2   = r_p;
        op_f    = r_p;
        case (r_kind)
            K_CORNER_TL: begin
            end
            K_TOP_A: begin
                sel_col = OUT_COL_W'(col_m1);
                op_n = r_l;  op_s1 = r_l;  op_s2 = r_p;  op_f = r_p;
            end
            K_TOP_B: begin
                sel_col = OUT_COL_W'(col_x2);
                op_n = r_p;  op_s1 = r_p;  op_s2 = r_l;  op_f = r_l;
            end
            K_CORNER_TR: begin
                sel_col = OUT_COL_W'({i_w_last, 1'b1});
            end
            K_LEFT_A: begin
                sel_row = OUT_ROW_W'(row_m1);
                op_n = r_u;  op_s1 = r_u;  op_s2 = r_p;  op_f = r_p;
            end
            K_LEFT_B: begin
                sel_row = OUT_ROW_W'(row_x2);
                op_n = r_p;  op_s1 = r_p;  op_s2 = r_u;  op_f = r_u;
            end
            K_CORNER_BL: begin
                sel_row = OUT_ROW_W'({i_h_last, 1'b1});
            end
            K_INT_A: begin
                sel_row = OUT_ROW_W'(row_m1);
                sel_col = OUT_COL_W'(col_m1);
                op_n = r_ul; op_s1 = r_u;  op_s2 = r_l;  op_f = r_p;
            end
            K_INT_B: begin
                sel_row = OUT_ROW_W'(row_m1);
                sel_col = OUT_COL_W'(col_x2);
                op_n = r_u;  op_s1 = r_ul; op_s2 = r_p;  op_f = r_l;
            end
            K_RIGHT_A: begin
                sel_row = OUT_ROW_W'(row_m1);
                sel_col = OUT_COL_W'({i_w_last, 1'b1});
                op_n = r_u;  op_s1 = r_u;  op_s2 = r_p;  op_f = r_p;
            end
            K_INT_C: begin
                sel_row = OUT_ROW_W'(row_x2);
                sel_col = OUT_COL_W'(col_m1);
                op_n = r_l;  op_s1 = r_ul; op_s2 = r_p;  op_f = r_u;
            end
            K_INT_D: begin
                sel_row = OUT_ROW_W'(row_x2);
                sel_col = OUT_COL_W'(col_x2);
                op_n = r_p;  op_s1 = r_u;  op_s2 = r_l;  op_f = r_ul;
            end
            K_RIGHT_B: begin
                sel_row = OUT_ROW_W'(row_x2);
                sel_col = OUT_COL_W'({i_w_last, 1'b1});
                op_n = r_p;  op_s1 = r_p;  op_s2 = r_u;  op_f = r_u;
            end
            K_BOT_A: begin
                sel_row = OUT_ROW_W'({i_h_last, 1'b1});
                sel_col = OUT_COL_W'(col_m1);
                op_n = r_l;  op_s1 = r_l;  op_s2 = r_p;  op_f = r_p;
            end
            K_BOT_B: begin
                sel_row = OUT_ROW_W'({i_h_last, 1'b1});
                sel_col = OUT_COL_W'(col_x2);
                op_n = r_p;  op_s1 = r_p;  op_s2 = r_l;  op_f = r_l;
            end
            K_CORNER_BR: begin
                sel_row = OUT_ROW_W'({i_h_last, 1'b1});
                sel_col = OUT_COL_W'({i_w_last, 1'b1});
            end
            default: begin
            end
        endcase
    end

    assign e_n  = SW'(op_n);
    assign e_s1 = SW'(op_s1);
    assign e_s2 = SW'(op_s2);
    assign e_f  = SW'(op_f);
    // 9n + 3s1 + 3s2 + f, rounded half up on the >>4
    assign sum  = (e_n << 3) + e_n + (e_s1 << 1) + e_s1 + (e_s2 << 1) + e_s2 + e_f
                  + SW'(8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (fire) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_row  <= sel_row;
            r_o_col  <= sel_col;
            r_o_val  <= sum[PIXEL_BITS+3:4];
            r_o_last <= step.done;
        end
    end

    assign o_res.valid        = r_o_vld;
    assign o_res.out_row      = r_o_row;
    assign o_res.out_col      = r_o_col;
    assign o_res.result_value = r_o_val;
    assign o_res.last_of_run  = r_o_last;

endmodule

// ===== hw/rtl/bilinear_upscale_2x_core.sv =====
// Top level of the streaming 2x bilinear upscaler: counters, line memory, sequencer.
`timescale 1ns / 1ps

// Takes input pixels in raster order and returns every output pixel of the
// 2x-upscaled image as soon as it can be computed, each with its output row
// and column; the final result of each input carries last_of_run. An input
// yields 1 to 9 results (4 in the interior) on the single result port, one
// per cycle while o_res.ready allows. The next input is taken while the
// current one is still producing results. An input passes the staging
// register, the sequencer's job registers and the output register on its way
// to its first result. The previous row lives in a MAX_WIDTH-entry line
// memory, read and written at the same column in the accept cycle (old data
// is read). The user must write width and height only while idle; the block
// does not enforce it. They are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT; a
// frame ends after width*height inputs and the next one starts at row 0.

`include "bilinear_upscale_2x_core_macros.svh"

module bilinear_upscale_2x_core
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bu2x_pix_if.sink              i_pix,
    bu2x_res_if.source            o_res
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);

    logic [CFG_WIDTH_W-1:0]  r_cfg_w;
    logic [CFG_HEIGHT_W-1:0] r_cfg_h;
    logic [COL_BITS-1:0]     w_last;
    logic [ROW_BITS-1:0]     h_last;

    logic [COL_BITS-1:0]     r_col, n_col;
    logic [ROW_BITS-1:0]     r_row, n_row;
    logic [PIXEL_BITS-1:0]   r_ul, r_left;

    logic [PIXEL_BITS-1:0]   mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]   r_rd_u;

    logic                    r_b_vld;
    logic [PIXEL_BITS-1:0]   r_b_pix;
    logic [ROW_BITS-1:0]     r_b_row;
    logic [COL_BITS-1:0]     r_b_col;
    t_flags                  r_b_flags;

    logic                    acc, b_move, emit_rdy;
    t_flags                  cur_flags;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_WIDTH_W'(2);
            r_cfg_h <= CFG_HEIGHT_W'(2);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_wdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_wdata[CFG_HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Index of the last column and row after clamping
    always_comb begin
        if (r_cfg_w < CFG_WIDTH_W'(2)) begin
            w_last = COL_BITS'(1);
        end else if (r_cfg_w > MAX_WIDTH) begin
            w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_BITS'(r_cfg_w - CFG_WIDTH_W'(1));
        end
        if (r_cfg_h < CFG_HEIGHT_W'(2)) begin
            h_last = ROW_BITS'(1);
        end else if (r_cfg_h > MAX_HEIGHT) begin
            h_last = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_BITS'(r_cfg_h - CFG_HEIGHT_W'(1));
        end
    end

    assign b_move      = r_b_vld && emit_rdy;
    assign i_pix.ready = !r_b_vld || b_move;
    assign acc         = i_pix.valid && i_pix.ready;

    // A counter at or past the last index counts as last (size shrank mid-frame).
    assign cur_flags.last_col = r_col >= w_last;
    assign cur_flags.last_row = r_row >= h_last;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (acc) begin
            if (cur_flags.last_col) begin
                n_col = '0;
                n_row = cur_flags.last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_b_vld <= 1'b0;
            r_ul    <= '0;
            r_left  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (acc) begin
                r_b_vld <= 1'b1;
            end else if (b_move) begin
                r_b_vld <= 1'b0;
            end
            if (b_move) begin
                r_ul   <= r_rd_u;
                r_left <= r_b_pix;
            end
        end
    end

    // Line memory: read the pixel above, then overwrite it with the new one.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_u     <= mem[r_col];
            mem[r_col] <= i_pix.pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_pix   <= i_pix.pixel_value;
            r_b_row   <= r_row;
            r_b_col   <= r_col;
            r_b_flags <= cur_flags;
        end
    end

    bu2x_emit #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS),
        .ROW_BITS   (ROW_BITS)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (r_b_vld),
        .o_job_rdy (emit_rdy),
        .i_p       (r_b_pix),
        .i_u       (r_rd_u),
        .i_ul      (r_ul),
        .i_l       (r_left),
        .i_row     (r_b_row),
        .i_col     (r_b_col),
        .i_flags   (r_b_flags),
        .i_w_last  (w_last),
        .i_h_last  (h_last),
        .o_res     (o_res)
    );

    `BU2X_ASSERT_NXT(a_acc_fills_b, i_clk, i_rst_n, acc, r_b_vld, "accepted item not staged")
    `BU2X_ASSERT_NXT(a_b_holds, i_clk, i_rst_n, r_b_vld && !b_move, r_b_vld && $stable(r_b_pix) && $stable(r_b_col), "staged item lost while stalled")
    `BU2X_ASSERT_IMP(a_col_in_mem, i_clk, i_rst_n, 1'b1, r_col < MAX_WIDTH, "column index beyond line memory")

endmodule
